### rtl/life_like_automaton_grid_assert.svh
// Assertion macros used by the checker of the automaton grid.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef LIFE_LIKE_AUTOMATON_GRID_ASSERT_SVH
`define LIFE_LIKE_AUTOMATON_GRID_ASSERT_SVH

// same-cycle implication
`define LLAG_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("life_like_automaton_grid: assertion failed");

// next-cycle implication
`define LLAG_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("life_like_automaton_grid: assertion failed");

`endif

### rtl/llag_pkg.sv
package llag_pkg;

  localparam int MAX_COLS = 64;
  localparam int MAX_ROWS = 64;

  localparam int ColAw   = $clog2(MAX_COLS);
  localparam int RowAw   = $clog2(MAX_ROWS);
  localparam int RowCntW = $clog2(MAX_ROWS + 1);

  localparam int MaskW    = 9;
  localparam int DimW     = 7;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 9;
  localparam int FuncW    = 2;
  localparam int InDataW  = 16;
  localparam int OutDataW = 8;

  typedef enum logic [FuncW-1:0] {
    FUNC_WRITE   = 2'd0,
    FUNC_READ    = 2'd1,
    FUNC_ADVANCE = 2'd2
  } func_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_BORN    = 2'd0,
    CFG_SURVIVE = 2'd1,
    CFG_WIDTH   = 2'd2,
    CFG_HEIGHT  = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [MaskW-1:0] born;
    logic [MaskW-1:0] survive;
  } rule_t;

endpackage

### rtl/llag_ram.sv
module llag_ram #(
  parameter int Width = 64,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/llag_next_row.sv
module llag_next_row (
  input  logic [llag_pkg::MAX_COLS-1:0] prev_i,
  input  logic [llag_pkg::MAX_COLS-1:0] cur_i,
  input  logic [llag_pkg::MAX_COLS-1:0] next_i,
  input  logic [llag_pkg::MAX_COLS-1:0] col_mask_i,
  input  llag_pkg::rule_t               rule_i,
  output logic [llag_pkg::MAX_COLS-1:0] row_o
);
  import llag_pkg::*;

  // zero guard column on both sides; columns past the width are masked off
  logic [MAX_COLS+1:0] p_pad, c_pad, n_pad;
  logic [MAX_COLS-1:0] nrow;

  assign p_pad = {1'b0, prev_i & col_mask_i, 1'b0};
  assign c_pad = {1'b0, cur_i  & col_mask_i, 1'b0};
  assign n_pad = {1'b0, next_i & col_mask_i, 1'b0};

  for (genvar c = 0; c < MAX_COLS; c++) begin : g_cell
    logic [3:0] cnt;
    assign cnt = {3'b0, p_pad[c]} + {3'b0, p_pad[c+1]} + {3'b0, p_pad[c+2]}
               + {3'b0, c_pad[c]} + {3'b0, c_pad[c+2]}
               + {3'b0, n_pad[c]} + {3'b0, n_pad[c+1]} + {3'b0, n_pad[c+2]};
    assign nrow[c] = c_pad[c+1] ? rule_i.survive[cnt] : rule_i.born[cnt];
  end

  // cells outside the active columns keep their stored value
  assign row_o = (nrow & col_mask_i) | (cur_i & ~col_mask_i);

endmodule

### rtl/life_like_automaton_grid.sv
// Life-like automaton grid: a MAX_ROWS x MAX_COLS bit grid held one row per word in a
// single-port-write, registered-read RAM. Each input transfer carries an operation in
// tuser: write cell, read cell or advance one generation under the born/survive masks;
// every operation returns exactly one result (cell value for reads, else 0, done bit set).
// Cell write and read: the row read at the input transfer arrives in ST_CELL, where the
// cell is written back or sampled, and the result is registered from ST_HOLD. An advance
// walks H = min(grid_height, MAX_ROWS) rows in ST_ADV, then moves to ST_HOLD: the
// sequencer streams one row a cycle through the RAM read port, a two-row line buffer and
// the neighbor-count logic, writing row r back while row r + 2 is read. An advance
// with H = 0 and the unused func code pass straight from the input transfer to
// ST_HOLD and write no RAM word. One item is worked on at a time; the result
// sits in an output register so the next item may be taken while it waits, and a finished
// item stalls until that register is free. The grid is dead right after reset through
// per-row valid flags, no clearing pass. Configuration writes land at once and must only
// be made while idle.
module life_like_automaton_grid (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // config write port
  input  logic                           cfg_we_i,
  input  logic [llag_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [llag_pkg::CfgDataW-1:0]  cfg_wdata_i,
  // input stream
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [llag_pkg::InDataW-1:0]   s_axis_tdata,  // col[5:0], row[11:6], cell_in[12]
  input  logic [llag_pkg::FuncW-1:0]     s_axis_tuser,  // func[1:0]
  // result stream
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [llag_pkg::OutDataW-1:0]  m_axis_tdata   // cell_out[0], done_res[1]
);
  import llag_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CELL,
    ST_ADV,
    ST_HOLD
  } state_e;

  state_e              state_q;
  logic [FuncW-1:0]    func_q;
  logic [RowAw-1:0]    row_addr_q;
  logic [ColAw-1:0]    col_q;
  logic                cell_q;
  logic                inside_q;
  logic                res_q;
  logic                out_valid_q;
  logic                cell_out_q;
  logic [RowCntW-1:0]  row_cnt_q;
  logic [MAX_COLS-1:0] saved_rows_q [2];
  logic                valid_q [MAX_ROWS];
  logic                rd_valid_q;
  rule_t               rule_q;
  logic [DimW-1:0]     grid_width_q;
  logic [DimW-1:0]     grid_height_q;

  logic [FuncW-1:0]    in_func;
  logic [5:0]          in_col;
  logic [5:0]          in_row;
  logic                in_cell;
  logic                in_inside;
  logic                accept;
  logic                out_free;

  logic [RowCntW-1:0]  height_eff;
  logic [MAX_COLS-1:0] col_mask;
  logic [MAX_COLS-1:0] row_data;
  logic [MAX_COLS-1:0] next_row;
  logic [MAX_COLS-1:0] new_row;
  logic [MAX_COLS-1:0] cell_wdata;

  logic                ram_we;
  logic [RowAw-1:0]    ram_waddr;
  logic [MAX_COLS-1:0] ram_wdata;
  logic [RowAw-1:0]    ram_raddr;
  logic [MAX_COLS-1:0] ram_rdata;

  assign in_func   = s_axis_tuser;
  assign in_col    = s_axis_tdata[5:0];
  assign in_row    = s_axis_tdata[11:6];
  assign in_cell   = s_axis_tdata[12];
  assign in_inside = (int'(in_col) < MAX_COLS) && (int'(in_row) < MAX_ROWS);

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OutDataW-2){1'b0}}, 1'b1, cell_out_q};

  assign height_eff = (int'(grid_height_q) > MAX_ROWS) ? RowCntW'(MAX_ROWS)
                                                      : RowCntW'(grid_height_q);

  for (genvar c = 0; c < MAX_COLS; c++) begin : g_mask
    assign col_mask[c] = int'(grid_width_q) > c;
  end

  // rows never written since reset read as dead
  assign row_data = ram_rdata & {MAX_COLS{rd_valid_q}};
  assign next_row = (row_cnt_q < height_eff) ? row_data : '0;

  always_comb begin
    cell_wdata        = row_data;
    cell_wdata[col_q] = cell_q;
  end

  llag_next_row u_next_row (
    .prev_i     (saved_rows_q[0]),
    .cur_i      (saved_rows_q[1]),
    .next_i     (next_row),
    .col_mask_i (col_mask),
    .rule_i     (rule_q),
    .row_o      (new_row)
  );

  always_comb begin
    ram_raddr = RowAw'(in_row);
    ram_we    = 1'b0;
    ram_waddr = row_addr_q;
    ram_wdata = cell_wdata;
    case (state_q)
      ST_IDLE: begin
        if (in_func == FUNC_ADVANCE) begin
          ram_raddr = '0;
        end
      end
      ST_CELL: begin
        ram_we = (func_q == FUNC_WRITE) && inside_q;
      end
      ST_ADV: begin
        // read row j+1 while row j arrives and row j-1 is written back
        ram_raddr = RowAw'(row_cnt_q + RowCntW'(1));
        ram_we    = (row_cnt_q != '0);
        ram_waddr = RowAw'(row_cnt_q - RowCntW'(1));
        ram_wdata = new_row;
      end
      default: ;
    endcase
  end

  llag_ram #(
    .Width (MAX_COLS),
    .Depth (MAX_ROWS)
  ) u_grid_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= ST_IDLE;
      func_q          <= '0;
      row_addr_q      <= '0;
      col_q           <= '0;
      cell_q          <= 1'b0;
      inside_q        <= 1'b0;
      res_q           <= 1'b0;
      out_valid_q     <= 1'b0;
      cell_out_q      <= 1'b0;
      row_cnt_q       <= '0;
      saved_rows_q    <= '{default: '0};
      valid_q         <= '{default: 1'b0};
      rd_valid_q      <= 1'b0;
      rule_q.born     <= MaskW'(8);
      rule_q.survive  <= MaskW'(12);
      grid_width_q    <= DimW'(64);
      grid_height_q   <= DimW'(64);
    end else begin
      rd_valid_q <= valid_q[ram_raddr];
      if (ram_we) begin
        valid_q[ram_waddr] <= 1'b1;
      end

      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_BORN:    rule_q.born    <= cfg_wdata_i[MaskW-1:0];
          CFG_SURVIVE: rule_q.survive <= cfg_wdata_i[MaskW-1:0];
          CFG_WIDTH:   grid_width_q   <= cfg_wdata_i[DimW-1:0];
          CFG_HEIGHT:  grid_height_q  <= cfg_wdata_i[DimW-1:0];
          default: ;
        endcase
      end

      // in hold, a result transfer frees the register for the next result
      if (m_axis_tvalid && m_axis_tready && (state_q != ST_HOLD)) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            func_q     <= in_func;
            row_addr_q <= RowAw'(in_row);
            col_q      <= ColAw'(in_col);
            cell_q     <= in_cell;
            inside_q   <= in_inside;
            res_q      <= 1'b0;
            case (in_func)
              FUNC_WRITE, FUNC_READ: begin
                state_q <= ST_CELL;
              end
              FUNC_ADVANCE: begin
                if (height_eff == '0) begin
                  state_q <= ST_HOLD;
                end else begin
                  saved_rows_q[0] <= '0;
                  row_cnt_q       <= '0;
                  state_q         <= ST_ADV;
                end
              end
              default: begin
                state_q <= ST_HOLD;
              end
            endcase
          end
        end
        ST_CELL: begin
          res_q   <= (func_q == FUNC_READ) && inside_q && row_data[col_q];
          state_q <= ST_HOLD;
        end
        ST_ADV: begin
          if (row_cnt_q == height_eff) begin
            state_q <= ST_HOLD;
          end else begin
            if (row_cnt_q != '0) begin
              saved_rows_q[0] <= saved_rows_q[1];
            end
            saved_rows_q[1] <= row_data;
            row_cnt_q       <= row_cnt_q + RowCntW'(1);
          end
        end
        ST_HOLD: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            cell_out_q  <= res_q;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

### rtl/llag_checker.sv
`include "life_like_automaton_grid_assert.svh"

module llag_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tvalid,
  input logic       s_axis_tready,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata
);

  // stalled result holds
  `LLAG_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
  // done flag always set, pad bits zero
  `LLAG_ASSERT_IMP(a_done_set, m_axis_tvalid, m_axis_tdata[1] && m_axis_tdata[7:2] == 6'd0)
  // one item at a time: busy right after an input transfer
  `LLAG_ASSERT_NXT(a_busy_after_in, s_axis_tvalid && s_axis_tready, !s_axis_tready)
  // a new result only appears as the block returns to idle
  `LLAG_ASSERT_IMP(a_result_on_idle, $rose(m_axis_tvalid), s_axis_tready)

endmodule

bind life_like_automaton_grid llag_checker u_llag_checker (.*);

### tb/life_like_automaton_grid_tb.sv
module life_like_automaton_grid_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import llag_pkg::*;

  // func code 3 is unused by the block: no effect, plain done result
  localparam logic [FuncW-1:0] FuncNone = 2'd3;
  localparam int IdleLimit = 4000;
  localparam int NumPhases = 12;
  localparam int PhaseItems = 150;

  typedef struct packed {
    logic [FuncW-1:0] func;
    logic [ColAw-1:0] col;
    logic [RowAw-1:0] row;
    logic             cell_in;
  } grid_op_t;

  typedef struct packed {
    logic cell_out;
    logic done_res;
  } grid_result_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]   cfg_index_i = '0;
  logic [CfgDataW-1:0]  cfg_wdata_i = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [InDataW-1:0]   s_axis_tdata = '0;   // col[5:0], row[11:6], cell_in[12]
  logic [FuncW-1:0]     s_axis_tuser = '0;   // func[1:0]
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OutDataW-1:0]  m_axis_tdata;        // cell_out[0], done_res[1]

  life_like_automaton_grid dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #6 clk_i = ~clk_i;

  // shadow of the grid and its rule registers
  logic [MAX_COLS-1:0] grid_q [MAX_ROWS];
  logic [MaskW-1:0]    born_r = 9'd8;
  logic [MaskW-1:0]    survive_r = 9'd12;
  logic [DimW-1:0]     width_r = 7'd64;
  logic [DimW-1:0]     height_r = 7'd64;

  grid_op_t     op_queue[$];
  grid_result_t cell_results_q[$];
  int           mismatches = 0;

  function automatic int bit_at(logic [MAX_COLS-1:0] line, int c);
    if (c < 0 || c > MAX_COLS - 1) return 0;
    return int'(line[c]);
  endfunction

  function automatic void step_generation();
    int w, h, n, r, c;
    logic [MAX_COLS-1:0] live_mask, prev_row, cur_row, next_row, new_row;
    logic [MaskW-1:0] rule;
    w = (int'(width_r) > MAX_COLS) ? MAX_COLS : int'(width_r);
    h = (int'(height_r) > MAX_ROWS) ? MAX_ROWS : int'(height_r);
    live_mask = (w >= MAX_COLS) ? '1 : ((64'd1 << w) - 64'd1);
    prev_row = '0;
    for (r = 0; r < h; r++) begin
      cur_row = grid_q[r] & live_mask;
      next_row = (r + 1 < h) ? (grid_q[r + 1] & live_mask) : '0;
      new_row = '0;
      for (c = 0; c < w; c++) begin
        // eight neighbors, the cell itself left out
        n = bit_at(prev_row, c - 1) + bit_at(prev_row, c) + bit_at(prev_row, c + 1)
          + bit_at(cur_row, c - 1) + bit_at(cur_row, c + 1)
          + bit_at(next_row, c - 1) + bit_at(next_row, c) + bit_at(next_row, c + 1);
        rule = cur_row[c] ? survive_r : born_r;
        new_row[c] = rule[n];
      end
      grid_q[r] = (new_row & live_mask) | (grid_q[r] & ~live_mask);
      prev_row = cur_row;
    end
  endfunction

  function automatic grid_result_t apply_grid_op(grid_op_t op);
    grid_result_t res;
    res.cell_out = 1'b0;
    res.done_res = 1'b1;
    case (op.func)
      FUNC_WRITE:   grid_q[op.row][op.col] = op.cell_in;
      FUNC_READ:    res.cell_out = grid_q[op.row][op.col];
      FUNC_ADVANCE: step_generation();
      default: ;
    endcase
    return res;
  endfunction

  // ---------------- driver ----------------
  grid_op_t     drive_op;
  grid_result_t drive_res;
  int           burst_left = 0;
  int           gap_left = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        drive_res = apply_grid_op(drive_op);
        cell_results_q.insert(cell_results_q.size(), drive_res);
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (op_queue.size() > 0) begin
          drive_op = op_queue.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= {3'b000, drive_op.cell_in, drive_op.row, drive_op.col};
          s_axis_tuser <= drive_op.func;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 24);
            case ($urandom_range(0, 3))
              0:       gap_left = 0;
              1, 2:    gap_left = $urandom_range(1, 4);
              default: gap_left = $urandom_range(5, 40);
            endcase
          end else begin
            burst_left--;
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------- monitor ----------------
  grid_result_t want_res;
  int           stall_mode = 0;
  int           mode_left = 0;
  logic         rdy_next;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (cell_results_q.size() == 0) begin
          $error("result transfer with nothing pending, tdata %h", m_axis_tdata);
          mismatches++;
        end else begin
          want_res = cell_results_q.pop_front();
          if (m_axis_tdata[0] !== want_res.cell_out) begin
            $error("cell_out: expected %0b, got %0b", want_res.cell_out, m_axis_tdata[0]);
            mismatches++;
          end
          if (m_axis_tdata[1] !== want_res.done_res) begin
            $error("done_res: expected %0b, got %0b", want_res.done_res, m_axis_tdata[1]);
            mismatches++;
          end
        end
      end
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 2);
        mode_left = $urandom_range(40, 300);
      end else begin
        mode_left--;
      end
      case (stall_mode)
        0:       rdy_next = 1'b1;
        1:       rdy_next = $urandom_range(0, 1) == 1;
        default: rdy_next = $urandom_range(0, 7) == 0;
      endcase
      m_axis_tready <= rdy_next;
    end
  end

  // ---------------- watchdog ----------------
  int idle_cycles = 0;

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IdleLimit) begin
      $display("FAIL life_like_automaton_grid");
      $finish;
    end
  end

  // ---------------- stimulus ----------------
  task automatic add_op(logic [FuncW-1:0] func, int row, int col, logic cell_in);
    grid_op_t op;
    op.func = func;
    op.row = row[RowAw-1:0];
    op.col = col[ColAw-1:0];
    op.cell_in = cell_in;
    op_queue.insert(op_queue.size(), op);
  endtask

  task automatic wait_idle();
    do @(negedge clk_i);
    while (op_queue.size() != 0 || s_axis_tvalid || cell_results_q.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic program_reg(cfg_idx_e idx, logic [CfgDataW-1:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    case (idx)
      CFG_BORN:    born_r = val[MaskW-1:0];
      CFG_SURVIVE: survive_r = val[MaskW-1:0];
      CFG_WIDTH:   width_r = val[DimW-1:0];
      default:     height_r = val[DimW-1:0];
    endcase
  endtask

  task automatic set_rules(logic [MaskW-1:0] b, logic [MaskW-1:0] s,
                           logic [DimW-1:0] w, logic [DimW-1:0] h);
    program_reg(CFG_BORN, b);
    program_reg(CFG_SURVIVE, s);
    program_reg(CFG_WIDTH, w);
    program_reg(CFG_HEIGHT, h);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [DimW-1:0] pick_dim();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return DimW'($urandom_range(1, 16));
      6, 7:             return DimW'($urandom_range(17, 64));
      8:                return 7'd64;
      default:          return DimW'($urandom_range(65, 127));
    endcase
  endfunction

  // coordinate mostly inside the active area, now and then anywhere in storage
  function automatic int pick_in(logic [DimW-1:0] dim);
    int lim;
    lim = (int'(dim) > 64) ? 64 : int'(dim);
    if (lim == 0 || $urandom_range(0, 15) == 0) return $urandom_range(0, 63);
    return $urandom_range(0, lim - 1);
  endfunction

  task automatic queue_phase(int n_items);
    int added, k, wr_n, rd_n, adv_n, density, f;
    added = 0;
    while (added < n_items) begin
      if ($urandom_range(0, 9) < 7) begin
        // seed a pattern, run it some generations, read it back
        wr_n = $urandom_range(3, 40);
        density = $urandom_range(10, 70);
        for (k = 0; k < wr_n; k++) begin
          add_op(FUNC_WRITE, pick_in(height_r), pick_in(width_r),
                 $urandom_range(0, 99) < density);
        end
        adv_n = $urandom_range(1, 3);
        for (k = 0; k < adv_n; k++) begin
          add_op(FUNC_ADVANCE, $urandom_range(0, 63), $urandom_range(0, 63),
                 1'($urandom_range(0, 1)));
          if ($urandom_range(0, 1) == 1)
            add_op(FUNC_READ, pick_in(height_r), pick_in(width_r),
                   1'($urandom_range(0, 1)));
        end
        rd_n = $urandom_range(4, 30);
        for (k = 0; k < rd_n; k++) begin
          add_op(FUNC_READ, pick_in(height_r), pick_in(width_r),
                 1'($urandom_range(0, 1)));
        end
        added += wr_n + adv_n + rd_n;
      end else begin
        k = $urandom_range(1, 10);
        repeat (k) begin
          f = $urandom_range(0, 3);
          add_op(f[FuncW-1:0], $urandom_range(0, 63), $urandom_range(0, 63),
                 1'($urandom_range(0, 1)));
          if (f[FuncW-1:0] != FuncNone) added++;
        end
      end
    end
  endtask

  initial begin
    int ph;
    foreach (grid_q[i]) grid_q[i] = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // corners, unused func code, clear of a live cell, then a blinker
    add_op(FUNC_WRITE, 0, 0, 1'b1);
    add_op(FUNC_WRITE, 63, 63, 1'b1);
    add_op(FUNC_READ, 0, 0, 1'b0);
    add_op(FUNC_READ, 63, 63, 1'b0);
    add_op(FuncNone, 63, 63, 1'b1);
    add_op(FUNC_WRITE, 63, 63, 1'b0);
    add_op(FUNC_READ, 63, 63, 1'b1);
    add_op(FUNC_WRITE, 10, 9, 1'b1);
    add_op(FUNC_WRITE, 10, 10, 1'b1);
    add_op(FUNC_WRITE, 10, 11, 1'b1);
    add_op(FUNC_ADVANCE, 0, 0, 1'b0);
    add_op(FUNC_READ, 9, 10, 1'b0);
    add_op(FUNC_READ, 11, 10, 1'b0);
    add_op(FUNC_READ, 10, 9, 1'b0);
    add_op(FUNC_READ, 0, 0, 1'b0);
    add_op(FUNC_ADVANCE, 63, 63, 1'b1);
    add_op(FUNC_READ, 10, 9, 1'b0);
    add_op(FUNC_READ, 9, 10, 1'b0);

    for (ph = 0; ph < NumPhases; ph++) begin
      wait_idle();
      case (ph)
        0:       set_rules(9'h000, 9'h000, 7'd1, 7'd1);
        1:       set_rules(9'h1FF, 9'h1FF, 7'd64, 7'd64);
        2:       set_rules(9'h008, 9'h00C, 7'd0, 7'd0);       // empty active area
        3:       set_rules(9'h001, 9'h100, 7'd127, 7'd127);   // oversize dims clamp
        4:       set_rules(9'h008, 9'h00C, 7'd8, 7'd5);
        default: set_rules(MaskW'($urandom_range(0, 511)), MaskW'($urandom_range(0, 511)),
                           pick_dim(), pick_dim());
      endcase
      queue_phase(PhaseItems);
    end

    wait_idle();
    repeat (80) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("PASS life_like_automaton_grid");
    end else begin
      $display("FAIL life_like_automaton_grid");
    end
    $finish;
  end

endmodule
